// ----- hw/rtl/clns_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// clns_pkg
// Shared types, codes and constants for the character display nibble
// sequencer.
// ----------------------------------------------------------------------------
package clns_pkg;

  // Request codes.
  typedef enum logic [2:0] {
    OP_INIT    = 3'd0,
    OP_COMMAND = 3'd1,
    OP_DATA    = 3'd2,
    OP_CURSOR  = 3'd3,
    OP_CLEAR   = 3'd4
  } opcode_e;

  // Register indexes on the configuration port.
  typedef enum logic [2:0] {
    REG_ENABLE_PULSE = 3'd0,
    REG_NIBBLE_GAP   = 3'd1,
    REG_COMMAND_WAIT = 3'd2,
    REG_DATA_WAIT    = 3'd3,
    REG_POWER_UP     = 3'd4,
    REG_FUNCTION_SET = 3'd5,
    REG_DISPLAY_CTRL = 3'd6,
    REG_ENTRY_MODE   = 3'd7
  } reg_idx_e;

  localparam int unsigned PaddrWidth = 5;
  localparam int unsigned StepCntWidth = 5;

  localparam logic [7:0]  EnablePulseRst = 8'd1;
  localparam logic [9:0]  NibbleGapRst   = 10'd100;
  localparam logic [13:0] CommandWaitRst = 14'd2000;
  localparam logic [9:0]  DataWaitRst    = 10'd100;
  localparam logic [15:0] PowerUpWaitRst = 16'd50000;
  localparam logic [7:0]  FunctionSetRst = 8'h28;
  localparam logic [7:0]  DisplayCtrlRst = 8'h0C;
  localparam logic [7:0]  EntryModeRst   = 8'h06;

  localparam logic [15:0] WakeWaitFirstUs = 16'd5000;
  localparam logic [15:0] WakeWaitNextUs  = 16'd1000;
  localparam logic [15:0] HoldMax         = 16'hFFFF;
  localparam logic [7:0]  CmdClear        = 8'h01;
  localparam logic [3:0]  WakeNibble      = 4'h3;
  localparam logic [3:0]  FourBitNibble   = 4'h2;

  // Step counter landmarks of the initialize run.
  localparam logic [StepCntWidth-1:0] StepPowerUp    = 5'd0;
  localparam logic [StepCntWidth-1:0] StepFirstWake2 = 5'd7;
  localparam logic [StepCntWidth-1:0] StepFirstByte  = 5'd9;
  localparam logic [StepCntWidth-1:0] StepFinalByte  = 5'd21;
  localparam logic [StepCntWidth-1:0] StepLast       = 5'd24;

  typedef struct packed {
    logic [7:0]  enable_pulse_us;
    logic [9:0]  nibble_gap_us;
    logic [13:0] command_wait_us;
    logic [9:0]  data_wait_us;
    logic [15:0] power_up_wait_us;
    logic [7:0]  function_set_word;
    logic [7:0]  display_control_word;
    logic [7:0]  entry_mode_word;
  } cfg_t;

  typedef enum logic [1:0] {
    KIND_POWER_UP = 2'd0,
    KIND_EN_HIGH  = 2'd1,
    KIND_EN_LOW   = 2'd2
  } step_kind_e;

  typedef enum logic [2:0] {
    NIB_ZERO    = 3'd0,
    NIB_WAKE3   = 3'd1,
    NIB_WAKE2   = 3'd2,
    NIB_BYTE_HI = 3'd3,
    NIB_BYTE_LO = 3'd4
  } nib_sel_e;

  typedef enum logic [1:0] {
    BYTE_FUNCTION = 2'd0,
    BYTE_DISPLAY  = 2'd1,
    BYTE_ENTRY    = 2'd2,
    BYTE_REQUEST  = 2'd3
  } byte_sel_e;

  typedef enum logic [2:0] {
    EXTRA_NONE       = 3'd0,
    EXTRA_WAKE_FIRST = 3'd1,
    EXTRA_WAKE_NEXT  = 3'd2,
    EXTRA_CMD        = 3'd3,
    EXTRA_CMD_TWICE  = 3'd4,
    EXTRA_DATA       = 3'd5
  } extra_sel_e;

  typedef enum logic {
    ST_IDLE = 1'b0,
    ST_RUN  = 1'b1
  } ctrl_state_e;

  // Controller to datapath command.
  typedef struct packed {
    logic       load;
    logic       emit;
    step_kind_e kind;
    nib_sel_e   nib_sel;
    byte_sel_e  byte_sel;
    extra_sel_e extra_sel;
    logic       rs;
    logic       last;
  } dp_cmd_t;

endpackage

// ----- hw/rtl/clns_regs.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// clns_regs
// Configuration register file behind an APB-style port.
// ----------------------------------------------------------------------------
module clns_regs (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               psel,
  input  logic                               penable,
  input  logic                               pwrite,
  input  logic [clns_pkg::PaddrWidth-1:0]    paddr,
  input  logic [31:0]                        pwdata,
  output logic [31:0]                        prdata,
  output logic                               pready,
  output clns_pkg::cfg_t                     cfg_o
);

  clns_pkg::cfg_t      cfg_q, cfg_d;
  clns_pkg::reg_idx_e  idx;
  logic                wr_en;

  assign pready = 1'b1;
  assign idx    = clns_pkg::reg_idx_e'(paddr[4:2]);
  assign wr_en  = psel & penable & pwrite;
  assign cfg_o  = cfg_q;

  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      unique case (idx)
        clns_pkg::REG_ENABLE_PULSE: cfg_d.enable_pulse_us      = pwdata[7:0];
        clns_pkg::REG_NIBBLE_GAP:   cfg_d.nibble_gap_us        = pwdata[9:0];
        clns_pkg::REG_COMMAND_WAIT: cfg_d.command_wait_us      = pwdata[13:0];
        clns_pkg::REG_DATA_WAIT:    cfg_d.data_wait_us         = pwdata[9:0];
        clns_pkg::REG_POWER_UP:     cfg_d.power_up_wait_us     = pwdata[15:0];
        clns_pkg::REG_FUNCTION_SET: cfg_d.function_set_word    = pwdata[7:0];
        clns_pkg::REG_DISPLAY_CTRL: cfg_d.display_control_word = pwdata[7:0];
        clns_pkg::REG_ENTRY_MODE:   cfg_d.entry_mode_word      = pwdata[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    prdata = 32'd0;
    unique case (idx)
      clns_pkg::REG_ENABLE_PULSE: prdata = {24'd0, cfg_q.enable_pulse_us};
      clns_pkg::REG_NIBBLE_GAP:   prdata = {22'd0, cfg_q.nibble_gap_us};
      clns_pkg::REG_COMMAND_WAIT: prdata = {18'd0, cfg_q.command_wait_us};
      clns_pkg::REG_DATA_WAIT:    prdata = {22'd0, cfg_q.data_wait_us};
      clns_pkg::REG_POWER_UP:     prdata = {16'd0, cfg_q.power_up_wait_us};
      clns_pkg::REG_FUNCTION_SET: prdata = {24'd0, cfg_q.function_set_word};
      clns_pkg::REG_DISPLAY_CTRL: prdata = {24'd0, cfg_q.display_control_word};
      clns_pkg::REG_ENTRY_MODE:   prdata = {24'd0, cfg_q.entry_mode_word};
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.enable_pulse_us      <= clns_pkg::EnablePulseRst;
      cfg_q.nibble_gap_us        <= clns_pkg::NibbleGapRst;
      cfg_q.command_wait_us      <= clns_pkg::CommandWaitRst;
      cfg_q.data_wait_us         <= clns_pkg::DataWaitRst;
      cfg_q.power_up_wait_us     <= clns_pkg::PowerUpWaitRst;
      cfg_q.function_set_word    <= clns_pkg::FunctionSetRst;
      cfg_q.display_control_word <= clns_pkg::DisplayCtrlRst;
      cfg_q.entry_mode_word      <= clns_pkg::EntryModeRst;
    end else begin
      cfg_q <= cfg_d;
    end
  end

endmodule

// ----- hw/rtl/clns_ctrl.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// clns_ctrl
// Sequencer state machine: walks the step counter of a request and tells
// the datapath what each pin step is made of.
// ----------------------------------------------------------------------------
module clns_ctrl (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  logic [2:0]           opcode_i,
  input  logic                 out_free_i,
  output clns_pkg::dp_cmd_t    cmd_o
);

  clns_pkg::ctrl_state_e                 state_q, state_d;
  logic [clns_pkg::StepCntWidth-1:0]     cnt_q, cnt_d;
  clns_pkg::opcode_e                     op_q, op_d;
  logic [clns_pkg::StepCntWidth-1:0]     rel;
  logic                                  accept;
  logic                                  known_op;

  assign rel = cnt_q - clns_pkg::StepFirstByte;
  assign in_stall_o = (state_q != clns_pkg::ST_IDLE);
  assign accept = in_valid_i & ~in_stall_o;
  assign known_op = (opcode_i <= 3'(clns_pkg::OP_CLEAR));

  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    op_d    = op_q;

    cmd_o.load      = 1'b0;
    cmd_o.emit      = 1'b0;
    cmd_o.kind      = clns_pkg::KIND_POWER_UP;
    cmd_o.nib_sel   = clns_pkg::NIB_ZERO;
    cmd_o.byte_sel  = clns_pkg::BYTE_REQUEST;
    cmd_o.extra_sel = clns_pkg::EXTRA_NONE;
    cmd_o.rs        = (op_q == clns_pkg::OP_DATA);
    cmd_o.last      = (cnt_q == clns_pkg::StepLast);

    // Step decode. Steps 1 to 8 are the wake nibbles; from step 9 on, each
    // group of four steps is one byte, high nibble first.
    if (cnt_q == clns_pkg::StepPowerUp) begin
      cmd_o.kind = clns_pkg::KIND_POWER_UP;
    end else if (cnt_q < clns_pkg::StepFirstByte) begin
      cmd_o.kind    = cnt_q[0] ? clns_pkg::KIND_EN_HIGH : clns_pkg::KIND_EN_LOW;
      cmd_o.nib_sel = (cnt_q >= clns_pkg::StepFirstWake2) ? clns_pkg::NIB_WAKE2
                                                          : clns_pkg::NIB_WAKE3;
      priority if (cnt_q == 5'd2) begin
        cmd_o.extra_sel = clns_pkg::EXTRA_WAKE_FIRST;
      end else if (cnt_q == 5'd4 || cnt_q == 5'd6) begin
        cmd_o.extra_sel = clns_pkg::EXTRA_WAKE_NEXT;
      end else begin
        cmd_o.extra_sel = clns_pkg::EXTRA_NONE;
      end
    end else begin
      cmd_o.kind     = rel[0] ? clns_pkg::KIND_EN_LOW : clns_pkg::KIND_EN_HIGH;
      cmd_o.nib_sel  = rel[1] ? clns_pkg::NIB_BYTE_LO : clns_pkg::NIB_BYTE_HI;
      cmd_o.byte_sel = clns_pkg::byte_sel_e'(rel[3:2]);
      if (rel[1:0] == 2'd3) begin
        if (rel[3:2] != 2'd3) begin
          cmd_o.extra_sel = clns_pkg::EXTRA_CMD;
        end else begin
          unique case (op_q)
            clns_pkg::OP_INIT,
            clns_pkg::OP_CLEAR: cmd_o.extra_sel = clns_pkg::EXTRA_CMD_TWICE;
            clns_pkg::OP_DATA:  cmd_o.extra_sel = clns_pkg::EXTRA_DATA;
            default:            cmd_o.extra_sel = clns_pkg::EXTRA_CMD;
          endcase
        end
      end
    end

    unique case (state_q)
      clns_pkg::ST_IDLE: begin
        if (accept && known_op) begin
          cmd_o.load = 1'b1;
          op_d       = clns_pkg::opcode_e'(opcode_i);
          cnt_d      = (op_d == clns_pkg::OP_INIT) ? clns_pkg::StepPowerUp
                                                   : clns_pkg::StepFinalByte;
          state_d    = clns_pkg::ST_RUN;
        end
      end
      clns_pkg::ST_RUN: begin
        if (out_free_i) begin
          cmd_o.emit = 1'b1;
          cnt_d      = cnt_q + 5'd1;
          if (cnt_q == clns_pkg::StepLast) begin
            state_d = clns_pkg::ST_IDLE;
          end
        end
      end
      default: state_d = clns_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= clns_pkg::ST_IDLE;
      cnt_q   <= clns_pkg::StepPowerUp;
      op_q    <= clns_pkg::OP_INIT;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      op_q    <= op_d;
    end
  end

endmodule

// ----- hw/rtl/clns_dp.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// clns_dp
// Datapath: holds the request byte, builds each pin step from the
// configuration and drives the output register.
// ----------------------------------------------------------------------------
module clns_dp (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  clns_pkg::cfg_t       cfg_i,
  input  clns_pkg::dp_cmd_t    cmd_i,
  output logic                 out_free_o,
  input  logic [2:0]           opcode_i,
  input  logic [7:0]           byte_value_i,
  input  logic                 row_i,
  input  logic [5:0]           column_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output logic                 register_select_o,
  output logic                 enable_o,
  output logic [3:0]           data_nibble_o,
  output logic [15:0]          hold_us_o,
  output logic                 last_o
);

  logic [7:0]  req_byte_q, req_byte_d;
  logic        out_valid_q, out_valid_d;
  logic        rs_q, en_q, last_q;
  logic [3:0]  nib_q, nib_d;
  logic [15:0] hold_q, hold_d;
  logic [7:0]  cur_byte;
  logic [15:0] extra;
  logic [16:0] low_sum;

  assign out_free_o = ~out_valid_q | ~out_stall_i;

  // Initialize ends with the same clear byte as the clear request. The row
  // base plus a column below 64 is just the row bit above the column.
  always_comb begin
    unique case (clns_pkg::opcode_e'(opcode_i))
      clns_pkg::OP_CURSOR:  req_byte_d = {1'b1, row_i, column_i};
      clns_pkg::OP_COMMAND,
      clns_pkg::OP_DATA:    req_byte_d = byte_value_i;
      default:              req_byte_d = clns_pkg::CmdClear;
    endcase
  end

  always_comb begin
    unique case (cmd_i.byte_sel)
      clns_pkg::BYTE_FUNCTION: cur_byte = cfg_i.function_set_word;
      clns_pkg::BYTE_DISPLAY:  cur_byte = cfg_i.display_control_word;
      clns_pkg::BYTE_ENTRY:    cur_byte = cfg_i.entry_mode_word;
      default:                 cur_byte = req_byte_q;
    endcase
  end

  always_comb begin
    unique case (cmd_i.nib_sel)
      clns_pkg::NIB_WAKE3:   nib_d = clns_pkg::WakeNibble;
      clns_pkg::NIB_WAKE2:   nib_d = clns_pkg::FourBitNibble;
      clns_pkg::NIB_BYTE_HI: nib_d = cur_byte[7:4];
      clns_pkg::NIB_BYTE_LO: nib_d = cur_byte[3:0];
      default:               nib_d = 4'd0;
    endcase
  end

  always_comb begin
    unique case (cmd_i.extra_sel)
      clns_pkg::EXTRA_WAKE_FIRST: extra = clns_pkg::WakeWaitFirstUs;
      clns_pkg::EXTRA_WAKE_NEXT:  extra = clns_pkg::WakeWaitNextUs;
      clns_pkg::EXTRA_CMD:        extra = {2'd0, cfg_i.command_wait_us};
      clns_pkg::EXTRA_CMD_TWICE:  extra = {1'b0, cfg_i.command_wait_us, 1'b0};
      clns_pkg::EXTRA_DATA:       extra = {6'd0, cfg_i.data_wait_us};
      default:                    extra = 16'd0;
    endcase
  end

  assign low_sum = {7'd0, cfg_i.nibble_gap_us} + {1'b0, extra};

  always_comb begin
    unique case (cmd_i.kind)
      clns_pkg::KIND_EN_HIGH: hold_d = {8'd0, cfg_i.enable_pulse_us};
      clns_pkg::KIND_EN_LOW:  hold_d = low_sum[16] ? clns_pkg::HoldMax : low_sum[15:0];
      default:                hold_d = cfg_i.power_up_wait_us;
    endcase
  end

  always_comb begin
    if (cmd_i.emit) begin
      out_valid_d = 1'b1;
    end else begin
      out_valid_d = out_valid_q & out_stall_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      req_byte_q <= req_byte_d;
    end
    if (cmd_i.emit) begin
      rs_q   <= cmd_i.rs;
      en_q   <= (cmd_i.kind == clns_pkg::KIND_EN_HIGH);
      nib_q  <= nib_d;
      hold_q <= hold_d;
      last_q <= cmd_i.last;
    end
  end

  assign out_valid_o       = out_valid_q;
  assign register_select_o = rs_q;
  assign enable_o          = en_q;
  assign data_nibble_o     = nib_q;
  assign hold_us_o         = hold_q;
  assign last_o            = last_q;

endmodule

// ----- hw/rtl/char_lcd_nibble_sequencer.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// char_lcd_nibble_sequencer
// Turns display requests into runs of pin steps for a character display on
// a 4-bit bus.
//
//   Channel   Handshake              Payload
//   request   in_valid_i/in_stall_o  opcode_i, byte_value_i, row_i, column_i
//   step      out_valid_o/out_stall_i register_select_o, enable_o,
//                                    data_nibble_o, hold_us_o, last_o
//   config    APB write/read         paddr, pwdata, prdata
//
// A request is taken while the block is idle and then plays one step per
// cycle from the step counter while the step channel is not stalled: 25
// steps for initialize, 4 for the others. Unknown opcodes are dropped in
// the accepting cycle. A stalled step holds the counter.
// Reset is asynchronous and restores the register defaults.
// ----------------------------------------------------------------------------
module char_lcd_nibble_sequencer (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  output logic                            in_stall_o,
  input  logic [2:0]                      opcode_i,
  input  logic [7:0]                      byte_value_i,
  input  logic                            row_i,
  input  logic [5:0]                      column_i,
  output logic                            out_valid_o,
  input  logic                            out_stall_i,
  output logic                            register_select_o,
  output logic                            enable_o,
  output logic [3:0]                      data_nibble_o,
  output logic [15:0]                     hold_us_o,
  output logic                            last_o,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [clns_pkg::PaddrWidth-1:0] paddr,
  input  logic [31:0]                     pwdata,
  output logic [31:0]                     prdata,
  output logic                            pready
);

  clns_pkg::cfg_t    cfg;
  clns_pkg::dp_cmd_t cmd;
  logic              out_free;

  clns_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  clns_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .opcode_i   (opcode_i),
    .out_free_i (out_free),
    .cmd_o      (cmd)
  );

  clns_dp u_dp (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cfg_i             (cfg),
    .cmd_i             (cmd),
    .out_free_o        (out_free),
    .opcode_i          (opcode_i),
    .byte_value_i      (byte_value_i),
    .row_i             (row_i),
    .column_i          (column_i),
    .out_valid_o       (out_valid_o),
    .out_stall_i       (out_stall_i),
    .register_select_o (register_select_o),
    .enable_o          (enable_o),
    .data_nibble_o     (data_nibble_o),
    .hold_us_o         (hold_us_o),
    .last_o            (last_o)
  );

endmodule

// ----- tb/tb_char_lcd_nibble_sequencer.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_char_lcd_nibble_sequencer
// Drives display requests and register settings into the nibble sequencer and
// checks every pin step it emits against steps worked out in the bench from
// the current register settings, with random idling on both channels.
// ----------------------------------------------------------------------------
module tb_char_lcd_nibble_sequencer;

  localparam int unsigned SettleCycles       = 30;
  localparam int unsigned IdleLimit          = 5000;
  localparam int unsigned BackpressureCycles = 300;
  localparam logic [2:0]  OpFirstUnknown     = 3'd5;
  localparam logic [2:0]  OpLastUnknown      = 3'd7;
  localparam logic [7:0]  Row0Base           = 8'h80;
  localparam logic [7:0]  Row1Base           = 8'hC0;

  typedef struct {
    logic [2:0] opcode;
    logic [7:0] byte_value;
    logic       row;
    logic [5:0] column;
  } lcd_req_t;

  typedef struct {
    logic        rs;
    logic        en;
    logic [3:0]  nibble;
    logic [15:0] hold_us;
    logic        last;
  } pin_step_t;

  logic                            clk_i = 1'b0;
  logic                            rst_ni = 1'b0;
  logic                            in_valid_i;
  logic                            in_stall_o;
  logic [2:0]                      opcode_i;
  logic [7:0]                      byte_value_i;
  logic                            row_i;
  logic [5:0]                      column_i;
  logic                            out_valid_o;
  logic                            out_stall_i;
  logic                            register_select_o;
  logic                            enable_o;
  logic [3:0]                      data_nibble_o;
  logic [15:0]                     hold_us_o;
  logic                            last_o;
  logic                            psel;
  logic                            penable;
  logic                            pwrite;
  logic [clns_pkg::PaddrWidth-1:0] paddr;
  logic [31:0]                     pwdata;
  logic [31:0]                     prdata;
  logic                            pready;

  clns_pkg::cfg_t shadow_cfg;
  pin_step_t      pending_steps[$];
  int unsigned    errors = 0;
  int unsigned    idle_cycles = 0;
  int unsigned    sink_gap = 0;
  int unsigned    sink_hold_req = 0;
  bit             src_idle = 1'b1;
  bit             sink_idle = 1'b1;

  char_lcd_nibble_sequencer dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_stall_o       (in_stall_o),
    .opcode_i         (opcode_i),
    .byte_value_i     (byte_value_i),
    .row_i            (row_i),
    .column_i         (column_i),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .register_select_o(register_select_o),
    .enable_o         (enable_o),
    .data_nibble_o    (data_nibble_o),
    .hold_us_o        (hold_us_o),
    .last_o           (last_o),
    .psel             (psel),
    .penable          (penable),
    .pwrite           (pwrite),
    .paddr            (paddr),
    .pwdata           (pwdata),
    .prdata           (prdata),
    .pready           (pready)
  );

  always #5 clk_i = ~clk_i;

  // ---------------------------------------------------------------- prediction

  function automatic logic [15:0] saturate_hold(int unsigned us);
    return (us > 32'd65535) ? clns_pkg::HoldMax : us[15:0];
  endfunction

  function automatic void add_step(logic rs, logic en, logic [3:0] nib, int unsigned hold);
    pin_step_t s;
    s.rs      = rs;
    s.en      = en;
    s.nibble  = nib;
    s.hold_us = saturate_hold(hold);
    s.last    = 1'b0;
    pending_steps.push_back(s);
  endfunction

  function automatic void add_nibble(logic rs, logic [3:0] nib, int unsigned extra);
    add_step(rs, 1'b1, nib, 32'(shadow_cfg.enable_pulse_us));
    add_step(rs, 1'b0, nib, 32'(shadow_cfg.nibble_gap_us) + extra);
  endfunction

  // The wait after a byte rides on the enable-low step of its low nibble.
  function automatic void add_byte(logic rs, logic [7:0] b, int unsigned extra);
    add_nibble(rs, b[7:4], 0);
    add_nibble(rs, b[3:0], extra);
  endfunction

  function automatic void plan_pin_steps(lcd_req_t req);
    int unsigned queued_prior;
    int unsigned cmd_wait;
    logic [7:0]  cursor_cmd;
    queued_prior = pending_steps.size();
    cmd_wait = 32'(shadow_cfg.command_wait_us);
    case (req.opcode)
      clns_pkg::OP_INIT: begin
        add_step(1'b0, 1'b0, 4'h0, 32'(shadow_cfg.power_up_wait_us));
        add_nibble(1'b0, clns_pkg::WakeNibble, 32'(clns_pkg::WakeWaitFirstUs));
        add_nibble(1'b0, clns_pkg::WakeNibble, 32'(clns_pkg::WakeWaitNextUs));
        add_nibble(1'b0, clns_pkg::WakeNibble, 32'(clns_pkg::WakeWaitNextUs));
        add_nibble(1'b0, clns_pkg::FourBitNibble, 0);
        add_byte(1'b0, shadow_cfg.function_set_word, cmd_wait);
        add_byte(1'b0, shadow_cfg.display_control_word, cmd_wait);
        add_byte(1'b0, shadow_cfg.entry_mode_word, cmd_wait);
        add_byte(1'b0, clns_pkg::CmdClear, 2 * cmd_wait);
      end
      clns_pkg::OP_COMMAND: add_byte(1'b0, req.byte_value, cmd_wait);
      clns_pkg::OP_DATA:
        add_byte(1'b1, req.byte_value, 32'(shadow_cfg.data_wait_us));
      clns_pkg::OP_CURSOR: begin
        cursor_cmd = (req.row ? Row1Base : Row0Base) + {2'b00, req.column};
        add_byte(1'b0, cursor_cmd, cmd_wait);
      end
      clns_pkg::OP_CLEAR:   add_byte(1'b0, clns_pkg::CmdClear, 2 * cmd_wait);
      default: ;
    endcase
    if (pending_steps.size() > queued_prior) begin
      pending_steps[pending_steps.size() - 1].last = 1'b1;
    end
  endfunction

  function automatic logic [31:0] reg_readback(clns_pkg::reg_idx_e idx);
    logic [31:0] v;
    v = '0;
    case (idx)
      clns_pkg::REG_ENABLE_PULSE: v = 32'(shadow_cfg.enable_pulse_us);
      clns_pkg::REG_NIBBLE_GAP:   v = 32'(shadow_cfg.nibble_gap_us);
      clns_pkg::REG_COMMAND_WAIT: v = 32'(shadow_cfg.command_wait_us);
      clns_pkg::REG_DATA_WAIT:    v = 32'(shadow_cfg.data_wait_us);
      clns_pkg::REG_POWER_UP:     v = 32'(shadow_cfg.power_up_wait_us);
      clns_pkg::REG_FUNCTION_SET: v = 32'(shadow_cfg.function_set_word);
      clns_pkg::REG_DISPLAY_CTRL: v = 32'(shadow_cfg.display_control_word);
      clns_pkg::REG_ENTRY_MODE:   v = 32'(shadow_cfg.entry_mode_word);
      default: ;
    endcase
    return v;
  endfunction

  function automatic void store_reg(clns_pkg::reg_idx_e idx, logic [31:0] value);
    case (idx)
      clns_pkg::REG_ENABLE_PULSE: shadow_cfg.enable_pulse_us      = value[7:0];
      clns_pkg::REG_NIBBLE_GAP:   shadow_cfg.nibble_gap_us        = value[9:0];
      clns_pkg::REG_COMMAND_WAIT: shadow_cfg.command_wait_us      = value[13:0];
      clns_pkg::REG_DATA_WAIT:    shadow_cfg.data_wait_us         = value[9:0];
      clns_pkg::REG_POWER_UP:     shadow_cfg.power_up_wait_us     = value[15:0];
      clns_pkg::REG_FUNCTION_SET: shadow_cfg.function_set_word    = value[7:0];
      clns_pkg::REG_DISPLAY_CTRL: shadow_cfg.display_control_word = value[7:0];
      clns_pkg::REG_ENTRY_MODE:   shadow_cfg.entry_mode_word      = value[7:0];
      default: ;
    endcase
  endfunction

  function automatic lcd_req_t make_req(logic [2:0] op, logic [7:0] bv, logic row,
                                        logic [5:0] col);
    lcd_req_t req;
    req.opcode     = op;
    req.byte_value = bv;
    req.row        = row;
    req.column     = col;
    return req;
  endfunction

  function automatic lcd_req_t random_request();
    lcd_req_t    req;
    int unsigned pick;
    pick = $urandom_range(0, 99);
    req.byte_value = 8'($urandom());
    req.row        = 1'($urandom());
    req.column     = 6'($urandom());
    if (pick < 8) req.opcode = clns_pkg::OP_INIT;
    else if (pick < 30) req.opcode = clns_pkg::OP_COMMAND;
    else if (pick < 55) req.opcode = clns_pkg::OP_DATA;
    else if (pick < 75) req.opcode = clns_pkg::OP_CURSOR;
    else if (pick < 90) req.opcode = clns_pkg::OP_CLEAR;
    else req.opcode = 3'($urandom_range(OpFirstUnknown, OpLastUnknown));
    return req;
  endfunction

  // ----------------------------------------------------------------- drivers

  task automatic reg_read_check(clns_pkg::reg_idx_e idx);
    @(negedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= {idx, 2'b00};
    @(negedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    if (prdata !== reg_readback(idx)) begin
      $error("prdata of %s: expected %0d, got %0d", idx.name(), reg_readback(idx), prdata);
      errors++;
    end
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic reg_write(clns_pkg::reg_idx_e idx, logic [31:0] value);
    @(negedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(negedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    store_reg(idx, value);
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    reg_read_check(idx);
  endtask

  // Expected steps are queued as the request is offered; none of them can
  // come out before it is taken, and earlier requests drain first.
  task automatic send_request(lcd_req_t req);
    int unsigned gap;
    gap = src_idle ? $urandom_range(0, 15) : 0;
    repeat (gap) begin
      @(negedge clk_i);
      in_valid_i <= 1'b0;
    end
    @(negedge clk_i);
    in_valid_i   <= 1'b1;
    opcode_i     <= req.opcode;
    byte_value_i <= req.byte_value;
    row_i        <= req.row;
    column_i     <= req.column;
    plan_pin_steps(req);
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
  endtask

  task automatic wait_for_steps;
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (pending_steps.size() != 0) @(posedge clk_i);
  endtask

  // Unknown requests leave nothing to wait for, so give the block time to
  // finish whatever it may still be playing.
  task automatic settle;
    wait_for_steps();
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  // ------------------------------------------------------------------- tests

  task automatic test_reset_defaults;
    for (int i = 0; i < 8; i++) reg_read_check(clns_pkg::reg_idx_e'(i));
    send_request(make_req(clns_pkg::OP_INIT, 8'h00, 1'b0, 6'd0));
    send_request(make_req(clns_pkg::OP_COMMAND, 8'h00, 1'b0, 6'd0));
    send_request(make_req(clns_pkg::OP_COMMAND, 8'hFF, 1'b1, 6'd63));
    send_request(make_req(clns_pkg::OP_DATA, 8'h00, 1'b0, 6'd0));
    send_request(make_req(clns_pkg::OP_DATA, 8'hFF, 1'b1, 6'd63));
    send_request(make_req(clns_pkg::OP_CURSOR, 8'h00, 1'b0, 6'd0));
    send_request(make_req(clns_pkg::OP_CURSOR, 8'hFF, 1'b1, 6'd63));
    send_request(make_req(clns_pkg::OP_CLEAR, 8'h00, 1'b0, 6'd0));
    for (int op = int'(OpFirstUnknown); op <= int'(OpLastUnknown); op++) begin
      send_request(make_req(op[2:0], 8'hFF, 1'b1, 6'd63));
    end
  endtask

  task automatic test_register_extremes;
    settle();
    for (int i = 0; i < 8; i++) reg_write(clns_pkg::reg_idx_e'(i), '1);
    send_request(make_req(clns_pkg::OP_INIT, 8'h00, 1'b0, 6'd0));
    send_request(make_req(clns_pkg::OP_DATA, 8'hA5, 1'b0, 6'd0));
    send_request(make_req(clns_pkg::OP_CLEAR, 8'h00, 1'b0, 6'd0));
    // All zero, including a zero enable pulse and no power-up wait.
    settle();
    for (int i = 0; i < 8; i++) reg_write(clns_pkg::reg_idx_e'(i), '0);
    send_request(make_req(clns_pkg::OP_INIT, 8'h00, 1'b0, 6'd0));
    send_request(make_req(clns_pkg::OP_COMMAND, 8'h5A, 1'b0, 6'd0));
    send_request(make_req(clns_pkg::OP_CURSOR, 8'h00, 1'b1, 6'd42));
    send_request(make_req(clns_pkg::OP_CLEAR, 8'h00, 1'b0, 6'd0));
  endtask

  task automatic test_backpressure;
    lcd_req_t req;
    settle();
    src_idle  = 1'b0;
    sink_idle = 1'b0;
    sink_hold_req = BackpressureCycles;
    for (int i = 0; i < 12; i++) begin
      req = random_request();
      req.opcode = (i % 3 == 0) ? clns_pkg::OP_INIT : clns_pkg::OP_DATA;
      send_request(req);
    end
  endtask

  task automatic test_sender_pause;
    lcd_req_t req;
    src_idle  = 1'b1;
    sink_idle = 1'b1;
    for (int i = 0; i < 10; i++) begin
      if (i == 5) wait_for_steps();
      req = random_request();
      send_request(req);
    end
  endtask

  task automatic test_random_traffic;
    lcd_req_t    req;
    int unsigned sent;
    logic [31:0] value;
    for (int phase = 0; phase < 4; phase++) begin
      settle();
      for (int i = 0; i < 8; i++) begin
        case ($urandom_range(0, 3))
          0: value = '0;
          1: value = '1;
          default: value = $urandom();
        endcase
        reg_write(clns_pkg::reg_idx_e'(i), value);
      end
      src_idle  = (phase % 2 == 0);
      sink_idle = (phase == 0 || phase == 3);
      sent = 0;
      while (sent < 16) begin
        req = random_request();
        send_request(req);
        if (req.opcode <= clns_pkg::OP_CLEAR) sent++;
      end
    end
  endtask

  // ----------------------------------------------------------------- checker

  always @(posedge clk_i) begin : step_check
    pin_step_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_steps.size() == 0) begin
        $error("unexpected pin step: rs=%0d en=%0d nibble=%h hold=%0d last=%0d",
               register_select_o, enable_o, data_nibble_o, hold_us_o, last_o);
        errors++;
      end else begin
        want = pending_steps.pop_front();
        if (register_select_o !== want.rs) begin
          $error("register_select: expected %0d, got %0d", want.rs, register_select_o);
          errors++;
        end
        if (enable_o !== want.en) begin
          $error("enable: expected %0d, got %0d", want.en, enable_o);
          errors++;
        end
        if (data_nibble_o !== want.nibble) begin
          $error("data_nibble: expected %h, got %h", want.nibble, data_nibble_o);
          errors++;
        end
        if (hold_us_o !== want.hold_us) begin
          $error("hold_us: expected %0d, got %0d", want.hold_us, hold_us_o);
          errors++;
        end
        if (last_o !== want.last) begin
          $error("last: expected %0d, got %0d", want.last, last_o);
          errors++;
        end
      end
      sink_gap = sink_idle ? $urandom_range(0, 15) : 0;
    end
  end

  // Step receiver: a long hold-off on request, else, while sink_idle is set,
  // a short random stall after each accepted step.
  initial begin : step_sink
    int unsigned hold_left;
    hold_left = 0;
    forever begin
      @(negedge clk_i);
      if (sink_hold_req != 0) begin
        hold_left = sink_hold_req;
        sink_hold_req = 0;
      end
      if (hold_left != 0) begin
        hold_left--;
        out_stall_i <= 1'b1;
      end else if (sink_gap != 0) begin
        sink_gap--;
        out_stall_i <= 1'b1;
      end else begin
        out_stall_i <= 1'b0;
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) ||
          (psel && penable && pready)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
      end
      if (idle_cycles >= IdleLimit) begin
        $display("tb_char_lcd_nibble_sequencer failed");
        $finish;
      end
    end
  end

  initial begin
    in_valid_i   = 1'b0;
    opcode_i     = '0;
    byte_value_i = '0;
    row_i        = 1'b0;
    column_i     = '0;
    out_stall_i  = 1'b0;
    psel         = 1'b0;
    penable      = 1'b0;
    pwrite       = 1'b0;
    paddr        = '0;
    pwdata       = '0;
    shadow_cfg   = {clns_pkg::EnablePulseRst, clns_pkg::NibbleGapRst,
                    clns_pkg::CommandWaitRst, clns_pkg::DataWaitRst,
                    clns_pkg::PowerUpWaitRst, clns_pkg::FunctionSetRst,
                    clns_pkg::DisplayCtrlRst, clns_pkg::EntryModeRst};
    repeat (7) @(negedge clk_i);
    rst_ni = 1'b1;

    test_reset_defaults();
    test_register_extremes();
    test_backpressure();
    test_sender_pause();
    test_random_traffic();

    settle();
    if (errors == 0 && pending_steps.size() == 0) begin
      $display("tb_char_lcd_nibble_sequencer passed");
    end else begin
      $display("tb_char_lcd_nibble_sequencer failed");
    end
    $finish;
  end

endmodule

// ----- files.f -----
hw/rtl/clns_pkg.sv
hw/rtl/clns_regs.sv
hw/rtl/clns_ctrl.sv
hw/rtl/clns_dp.sv
hw/rtl/char_lcd_nibble_sequencer.sv
tb/tb_char_lcd_nibble_sequencer.sv
